@@ rtl/lwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and fixed field widths of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lwd_pkg;

    // Fixed token and result field widths
    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 17;
    localparam int LCODE_W = 6;

    // One unpacked input token
    typedef struct packed {
        logic               is_match;
        logic [BYTE_W-1:0]  literal;
        logic [DIST_W-1:0]  distance;
        logic [LCODE_W-1:0] length_code;
    } token_t;

    // One output transaction: up to two decoded bytes
    typedef struct packed {
        logic [BYTE_W-1:0] byte_first;
        logic [BYTE_W-1:0] byte_second;
        logic              second_valid;
        logic              last;
        logic              bad_reference;
    } result_t;

    // Control from the sequencer to the history window
    typedef struct packed {
        logic rd_en;
        logic wr_first;
        logic wr_second;
    } win_ctrl_t;

endpackage

@@ rtl/lzss_window_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS token decoder with a sliding history window held in two byte banks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive token and raise start; the token is taken at a clock edge where
//   start is high and busy is low. Results leave on result, one transaction
//   per cycle while result_valid is high; the receiver cannot stall them.
//   A literal gives one result in the cycle after it is taken, and busy
//   stays low, so literals can enter every cycle.
//   A match of L bytes (L = length_code + MIN_MATCH) gives ceil(L/2)
//   results on consecutive cycles. After the token is taken, pair reads
//   issue in ST_RUN; each pair is registered at the window bank outputs,
//   then in the result register. busy stays high while reads run, the
//   window banks reading one byte pair per cycle, and until the final pair
//   is written back, as that must happen before the next token reads the window.
//   A match that reaches past the bytes held gives one result with
//   bad_reference set in the cycle after it is taken; no state changes.
//   Reset clears the write pointer and the fill count; the history banks
//   are not cleared and their contents are never read before being written.
// ----------------------------------------------------------------------------
module lzss_window_decoder #(
    parameter int WINDOW_BITS = 17,
    parameter int LENGTH_BITS = 6,
    parameter int MIN_MATCH   = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lwd_pkg::token_t   token,
    output logic              busy,
    output logic              result_valid,
    output lwd_pkg::result_t  result
);

    localparam int MAX_LEN = (1 << LENGTH_BITS) - 1 + MIN_MATCH;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int DIST_W  = lwd_pkg::DIST_W;
    localparam int CMP_W   = ((WINDOW_BITS + 1 > DIST_W) ? WINDOW_BITS + 1 : DIST_W) + 1;
    localparam logic [WINDOW_BITS:0] WIN_SIZE = {1'b1, {WINDOW_BITS{1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [WINDOW_BITS-1:0]     src_reg, src_next;
    logic [WINDOW_BITS-1:0]     dst_reg, dst_next;
    logic [LEN_W-1:0]           left_reg, left_next;
    logic                       rdv_reg, rdv_next;
    logic                       rd_second_reg, rd_second_next;
    logic                       rd_last_reg, rd_last_next;
    logic [WINDOW_BITS-1:0]     wdst_reg, wdst_next;
    logic [WINDOW_BITS-1:0]     wp_reg, wp_next;
    logic [WINDOW_BITS:0]       fill_reg, fill_next;
    lwd_pkg::result_t           result_reg, result_next;
    logic                       result_valid_reg, result_valid_next;

    logic                       accept;
    logic [LENGTH_BITS-1:0]     code;
    logic [LEN_W-1:0]           match_len;
    logic [CMP_W-1:0]           dist_ext;
    logic [CMP_W-1:0]           need;
    logic                       bad;
    logic [WINDOW_BITS-1:0]     oldest;
    logic [WINDOW_BITS-1:0]     src_start;
    logic [1:0]                 wr_count;
    logic [WINDOW_BITS:0]       fill_sum;

    lwd_pkg::win_ctrl_t         win_ctrl;
    logic [WINDOW_BITS-1:0]     win_rd_addr;
    logic [WINDOW_BITS-1:0]     win_wr_addr;
    logic [lwd_pkg::BYTE_W-1:0] win_wr_first;
    logic [lwd_pkg::BYTE_W-1:0] win_wr_second;
    logic [lwd_pkg::BYTE_W-1:0] rd_first;
    logic [lwd_pkg::BYTE_W-1:0] rd_second;

    lwd_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk            (clk),
        .ctrl           (win_ctrl),
        .rd_addr        (win_rd_addr),
        .wr_addr        (win_wr_addr),
        .wr_first_data  (win_wr_first),
        .wr_second_data (win_wr_second),
        .rd_first       (rd_first),
        .rd_second      (rd_second)
    );

    // Hold off new tokens while reads run or the final pair is still in flight
    assign busy   = (state_reg == ST_RUN) || rdv_reg;
    assign accept = start && !busy;

    // Decode the token: length, bound check, start address in the window
    always_comb
    begin
        code      = token.length_code[LENGTH_BITS-1:0];
        match_len = LEN_W'(code) + LEN_W'(MIN_MATCH);
        dist_ext  = CMP_W'(token.distance);
        need      = dist_ext + CMP_W'(match_len);
        bad       = need > CMP_W'(fill_reg);
        oldest    = wp_reg - fill_reg[WINDOW_BITS-1:0];
        src_start = oldest + dist_ext[WINDOW_BITS-1:0];
    end

    // Sequence the reads, write back the copied bytes, form results
    always_comb
    begin
        state_next        = state_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        left_next         = left_reg;
        rdv_next          = 1'b0;
        rd_second_next    = rd_second_reg;
        rd_last_next      = rd_last_reg;
        wdst_next         = wdst_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        win_ctrl          = '0;
        win_rd_addr       = src_reg;
        win_wr_addr       = wdst_reg;
        win_wr_first      = rd_first;
        win_wr_second     = rd_second;
        wr_count          = 2'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && token.is_match && !bad)
                begin
                    src_next   = src_start;
                    dst_next   = wp_reg;
                    left_next  = match_len;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Issue one pair read and advance
                win_ctrl.rd_en = 1'b1;
                rdv_next       = 1'b1;
                rd_second_next = left_reg >= LEN_W'(2);
                rd_last_next   = left_reg <= LEN_W'(2);
                wdst_next      = dst_reg;
                src_next       = src_reg + WINDOW_BITS'(2);
                dst_next       = dst_reg + WINDOW_BITS'(2);
                left_next      = left_reg - LEN_W'(2);
                if (left_reg <= LEN_W'(2))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Emit/append the pair read in the previous cycle or a literal; flag a bad match
        priority if (rdv_reg)
        begin
            win_ctrl.wr_first          = 1'b1;
            win_ctrl.wr_second         = rd_second_reg;
            wr_count                   = rd_second_reg ? 2'd2 : 2'd1;
            result_next.byte_first     = rd_first;
            result_next.byte_second    = rd_second_reg ? rd_second : '0;
            result_next.second_valid   = rd_second_reg;
            result_next.last           = rd_last_reg;
            result_next.bad_reference  = 1'b0;
            result_valid_next          = 1'b1;
        end
        else if (accept && !token.is_match)
        begin
            win_ctrl.wr_first          = 1'b1;
            win_wr_addr                = wp_reg;
            win_wr_first               = token.literal;
            wr_count                   = 2'd1;
            result_next.byte_first     = token.literal;
            result_next.byte_second    = '0;
            result_next.second_valid   = 1'b0;
            result_next.last           = 1'b1;
            result_next.bad_reference  = 1'b0;
            result_valid_next          = 1'b1;
        end
        else if (accept && bad)
        begin
            result_next.byte_first     = '0;
            result_next.byte_second    = '0;
            result_next.second_valid   = 1'b0;
            result_next.last           = 1'b1;
            result_next.bad_reference  = 1'b1;
            result_valid_next          = 1'b1;
        end
        else
        begin
            wr_count = 2'd0;
        end
    end

    // Advance the write pointer and saturate the fill count at the window size
    always_comb
    begin
        wp_next   = wp_reg + WINDOW_BITS'(wr_count);
        fill_sum  = fill_reg + (WINDOW_BITS + 1)'(wr_count);
        fill_next = (fill_sum > WIN_SIZE) ? WIN_SIZE : fill_sum;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rdv_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            wp_reg           <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rdv_reg          <= rdv_next;
            result_valid_reg <= result_valid_next;
            wp_reg           <= wp_next;
            fill_reg         <= fill_next;
        end
    end

    // Payload and address registers
    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        left_reg      <= left_next;
        rd_second_reg <= rd_second_next;
        rd_last_reg   <= rd_last_next;
        wdst_reg      <= wdst_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/lwd_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_window
// History window split into an even and an odd byte bank, so that any two
// consecutive byte addresses can be read or written together.
// ----------------------------------------------------------------------------
module lwd_window #(
    parameter int WINDOW_BITS = 17
) (
    input  logic                      clk,
    input  lwd_pkg::win_ctrl_t        ctrl,
    input  logic [WINDOW_BITS-1:0]    rd_addr,
    input  logic [WINDOW_BITS-1:0]    wr_addr,
    input  logic [lwd_pkg::BYTE_W-1:0] wr_first_data,
    input  logic [lwd_pkg::BYTE_W-1:0] wr_second_data,
    output logic [lwd_pkg::BYTE_W-1:0] rd_first,
    output logic [lwd_pkg::BYTE_W-1:0] rd_second
);

    localparam int IDX_W = WINDOW_BITS - 1;
    localparam int DEPTH = 1 << IDX_W;

    logic [lwd_pkg::BYTE_W-1:0] even_mem [DEPTH];
    logic [lwd_pkg::BYTE_W-1:0] odd_mem  [DEPTH];

    logic [IDX_W-1:0]           rd_even_idx;
    logic [IDX_W-1:0]           rd_odd_idx;
    logic [IDX_W-1:0]           wr_even_idx;
    logic [IDX_W-1:0]           wr_odd_idx;
    logic                       even_we;
    logic                       odd_we;
    logic [lwd_pkg::BYTE_W-1:0] even_wdata;
    logic [lwd_pkg::BYTE_W-1:0] odd_wdata;
    logic [lwd_pkg::BYTE_W-1:0] even_q_reg;
    logic [lwd_pkg::BYTE_W-1:0] odd_q_reg;
    logic                       swap_reg;

    // Map a byte pair onto the two banks; an odd start wraps into the next even row
    always_comb
    begin
        rd_odd_idx  = rd_addr[WINDOW_BITS-1:1];
        rd_even_idx = rd_addr[WINDOW_BITS-1:1] + IDX_W'(rd_addr[0]);
        wr_odd_idx  = wr_addr[WINDOW_BITS-1:1];
        wr_even_idx = wr_addr[WINDOW_BITS-1:1] + IDX_W'(wr_addr[0]);
        even_we     = (ctrl.wr_first & ~wr_addr[0]) | (ctrl.wr_second & wr_addr[0]);
        odd_we      = (ctrl.wr_first & wr_addr[0]) | (ctrl.wr_second & ~wr_addr[0]);
        even_wdata  = wr_addr[0] ? wr_second_data : wr_first_data;
        odd_wdata   = wr_addr[0] ? wr_first_data : wr_second_data;
    end

    // Even bank: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[wr_even_idx] <= even_wdata;
        end
        if (ctrl.rd_en)
        begin
            even_q_reg <= even_mem[rd_even_idx];
        end
    end

    // Odd bank: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (odd_we)
        begin
            odd_mem[wr_odd_idx] <= odd_wdata;
        end
        if (ctrl.rd_en)
        begin
            odd_q_reg <= odd_mem[rd_odd_idx];
        end
    end

    // Remember which bank holds the first byte of the pair
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            swap_reg <= rd_addr[0];
        end
    end

    assign rd_first  = swap_reg ? odd_q_reg : even_q_reg;
    assign rd_second = swap_reg ? even_q_reg : odd_q_reg;

endmodule

@@ rtl/lwd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_port_checker
// Port-level checks of the LZSS window decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lwd_port_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input lwd_pkg::token_t  token,
    input logic             busy,
    input logic             result_valid,
    input lwd_pkg::result_t result
);

    // A literal transaction returns its own byte as a single final result
    a_literal_echo: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !token.is_match |=>
            result_valid && result.last && !result.bad_reference &&
            !result.second_valid && result.byte_first == $past(token.literal))
        else $error("literal transaction did not return its byte");

    // Results of one match come back to back until the last one
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside a match result burst");

    // More results pending means the block still holds off new tokens
    a_busy_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("busy dropped before the final result");

    // An error result is final and carries no bytes
    a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_reference |->
            result.last && !result.second_valid &&
            result.byte_first == 8'd0 && result.byte_second == 8'd0)
        else $error("error result carries bytes or is not final");

    // An idle block taking no token shows no result next cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !result_valid)
        else $error("result without a transaction");

endmodule

bind lzss_window_decoder lwd_port_checker u_lwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .token        (token),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

@@ verif/lwd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_checker
// Watches the token and result channels of the LZSS window decoder. It keeps
// its own copy of the history window, works out the result transactions that
// each accepted token must cause, and compares every result transaction
// field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module lwd_checker #(
    parameter int MIN_MATCH = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lwd_pkg::token_t   token,
    input  logic              busy,
    input  logic              result_valid,
    input  lwd_pkg::result_t  result,
    output int unsigned       fail_count,
    output int unsigned       pending
);

    import lwd_pkg::*;

    localparam int WIN_SIZE = 1 << DIST_W;
    localparam int MAX_LEN  = (1 << LCODE_W) - 1 + MIN_MATCH;

    // Mirror of the decoder window
    logic [BYTE_W-1:0] window_mem [0:WIN_SIZE-1];
    logic [DIST_W-1:0] wr_ptr;
    int unsigned       bytes_held;
    int unsigned       errors;

    // Decoded transactions still owed by the block, oldest first
    result_t decoded_q [$];

    // Append one byte, dropping the oldest once the window is full
    task automatic append_byte(input logic [BYTE_W-1:0] b);
        window_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (bytes_held < WIN_SIZE)
        begin
            bytes_held++;
        end
    endtask

    // Work out the result transactions of one token and update the window
    task automatic decode_token(input token_t tk);
        logic [BYTE_W-1:0] copy_buf [0:MAX_LEN-1];
        logic [DIST_W-1:0] oldest;
        int unsigned       len;
        int unsigned       i;
        result_t           r;

        len = int'(tk.length_code) + MIN_MATCH;
        r   = '0;
        if (!tk.is_match)
        begin
            append_byte(tk.literal);
            r.byte_first = tk.literal;
            r.last       = 1'b1;
            decoded_q.push_back(r);
        end
        else if (tk.distance + len > bytes_held)
        begin
            // Out-of-range copy: error transaction, window untouched
            r.last          = 1'b1;
            r.bad_reference = 1'b1;
            decoded_q.push_back(r);
        end
        else
        begin
            // Snapshot the source bytes before any of them is appended
            oldest = wr_ptr - DIST_W'(bytes_held);
            for (i = 0; i < len; i++)
            begin
                copy_buf[i] = window_mem[DIST_W'(oldest + tk.distance + i)];
            end
            for (i = 0; i < len; i += 2)
            begin
                r            = '0;
                r.byte_first = copy_buf[i];
                if (i + 1 < len)
                begin
                    r.byte_second  = copy_buf[i + 1];
                    r.second_valid = 1'b1;
                end
                r.last = (i + 2 >= len);
                decoded_q.push_back(r);
            end
            for (i = 0; i < len; i++)
            begin
                append_byte(copy_buf[i]);
            end
        end
    endtask

    function automatic int unsigned field_differs(input string             name,
                                                  input logic [BYTE_W-1:0] want,
                                                  input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check result transactions, then record accepted tokens
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;

        if (!rst_n)
        begin
            wr_ptr     = '0;
            bytes_held = 0;
            errors     = 0;
            decoded_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t ns: result expected none, got %0h", $time, result);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    errors += field_differs("byte_first", want.byte_first,
                                            result.byte_first);
                    errors += field_differs("byte_second", want.byte_second,
                                            result.byte_second);
                    errors += field_differs("second_valid", want.second_valid,
                                            result.second_valid);
                    errors += field_differs("last", want.last, result.last);
                    errors += field_differs("bad_reference", want.bad_reference,
                                            result.bad_reference);
                end
            end
            if (start && !busy)
            begin
                decode_token(token);
            end
            fail_count <= errors;
            pending    <= decoded_q.size();
        end
    end

endmodule

@@ verif/tb_lzss_window_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lzss_window_decoder
// Regression for the LZSS window decoder. A directed opening covers literal
// extremes, odd and even copy lengths, copies ending exactly at the newest
// byte and one past it, and wide distances. Random tokens follow in a
// growing window. The sender idles at random in phases; lwd_checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_lzss_window_decoder;

    import lwd_pkg::*;

    localparam int          MIN_MATCH    = 3;
    localparam int          WIN_SIZE     = 1 << DIST_W;
    localparam int          MAX_CODE     = (1 << LCODE_W) - 1;
    localparam int          RANDOM_ITEMS = 360;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam logic        KIND_LITERAL = 1'b0;
    localparam logic        KIND_MATCH   = 1'b1;

    logic    clk;
    logic    rst_n;
    logic    start;
    token_t  token;
    logic    busy;
    logic    result_valid;
    result_t result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    // Bytes held in the window, to shape copies
    int unsigned held;
    int unsigned idle_pct;
    int unsigned idle_plan [4] = '{0, 65, 0, 14};

    lzss_window_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .token        (token),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    lwd_checker #(
        .MIN_MATCH (MIN_MATCH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .token        (token),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lzss_window_decoder regression: fail");
            $finish;
        end
    end

    function automatic token_t literal_token(input logic [BYTE_W-1:0] b);
        token_t tk;

        tk.is_match    = KIND_LITERAL;
        tk.literal     = b;
        tk.distance    = DIST_W'($urandom);
        tk.length_code = LCODE_W'($urandom);
        return tk;
    endfunction

    function automatic token_t match_token(input int unsigned start_idx,
                                           input int unsigned code);
        token_t tk;

        tk.is_match    = KIND_MATCH;
        tk.literal     = BYTE_W'($urandom);
        tk.distance    = DIST_W'(start_idx);
        tk.length_code = LCODE_W'(code);
        return tk;
    endfunction

    // Idle at random, then hold the token until the block takes it
    task automatic send_token(input token_t tk);
        int unsigned len;

        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        token <= tk;
        do
            @(posedge clk);
        while (busy);

        // Track the window fill for shaping later tokens
        len = int'(tk.length_code) + MIN_MATCH;
        if (tk.is_match == KIND_LITERAL)
        begin
            len = 1;
        end
        if (tk.is_match == KIND_LITERAL || tk.distance + len <= held)
        begin
            held = (held + len > WIN_SIZE) ? WIN_SIZE : held + len;
        end
    endtask

    // Copy that stays within the bytes held, often from the newest bytes
    task automatic send_good_match();
        int unsigned code;
        int unsigned len;
        int unsigned start_idx;

        code = $urandom_range((held - MIN_MATCH > MAX_CODE) ? MAX_CODE : held - MIN_MATCH);
        len  = code + MIN_MATCH;
        if ($urandom_range(1))
        begin
            start_idx = held - len - $urandom_range((held - len > 64) ? 64 : held - len);
        end
        else
        begin
            start_idx = $urandom_range(held - len);
        end
        send_token(match_token(start_idx, code));
    endtask

    // Copy that runs past the bytes held, sometimes by exactly one
    task automatic send_bad_match();
        int unsigned code;
        int unsigned lo;

        code = $urandom_range(MAX_CODE);
        lo   = (held + 1 > code + MIN_MATCH) ? held + 1 - code - MIN_MATCH : 0;
        if ($urandom_range(3) == 0)
        begin
            send_token(match_token(lo, code));
        end
        else
        begin
            send_token(match_token($urandom_range(WIN_SIZE - 1, lo), code));
        end
    endtask

    task automatic send_random_token();
        int unsigned pick;

        pick = $urandom_range(99);
        if (pick < 40 || (pick < 85 && held < MIN_MATCH))
        begin
            send_token(literal_token(BYTE_W'($urandom)));
        end
        else if (pick < 85)
        begin
            send_good_match();
        end
        else
        begin
            send_bad_match();
        end
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            idle_pct = idle_plan[(n / 32) % 4];
            send_random_token();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        token       = '0;
        held        = 0;
        idle_pct    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty window: any copy is out of range
        send_token(match_token(0, 0));

        // Literal extremes
        send_token(literal_token(8'h00));
        send_token(literal_token(8'hFF));
        send_token(literal_token(8'hA5));
        send_token(literal_token(8'h5A));
        send_token(literal_token(8'h01));
        send_token(literal_token(8'h80));

        // Copies ending at the newest byte, one past it, odd and even lengths
        send_token(match_token(3, 0));
        send_token(match_token(4, 3));
        send_token(match_token(0, 3));
        send_token(match_token(0, 12));
        send_token(match_token(0, 27));
        send_token(match_token(10, 47));
        send_token(match_token(44, MAX_CODE));
        send_token(match_token(111, MAX_CODE));

        // Wide distances
        send_token(match_token(WIN_SIZE - 1, 0));
        send_token(match_token(WIN_SIZE / 2, MAX_CODE));
        send_token(match_token(173, 0));
        send_token(literal_token(8'h7E));

        // Random tokens in a partly filled window
        run_random(RANDOM_ITEMS / 2);

        // More random tokens as the window keeps growing
        run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        // Drain, then watch for stray results
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("lzss_window_decoder regression: pass");
        end
        else
        begin
            $display("lzss_window_decoder regression: fail");
        end
        $finish;
    end

endmodule

@@ lzss_window_decoder.f @@
rtl/lwd_pkg.sv
rtl/lwd_window.sv
rtl/lzss_window_decoder.sv
rtl/lwd_checker.sv
verif/lwd_checker.sv
verif/tb_lzss_window_decoder.sv
